@@ sv/frsq_pkg.sv @@
// ============================================================================
// frsq_pkg - shared types and constants of the float32 sqrt / rsqrt unit
// Holds the special-case bit patterns and the pipeline word that moves
// between the prepare, iteration and fixup sections.
// ============================================================================
package frsq_pkg;

    localparam logic [31:0] QNAN_BITS     = 32'h7FC0_0001;
    localparam logic [31:0] POS_INF_BITS  = 32'h7F80_0000;
    localparam logic [31:0] NEG_INF_BITS  = 32'hFF80_0000;
    localparam logic [31:0] NEG_ZERO_BITS = 32'h8000_0000;
    localparam logic [31:0] ZERO_BITS     = 32'h0000_0000;
    localparam logic [31:0] RSQRT_B_INIT  = 32'h4000_0000;

    localparam int ITER_STEPS = 13;

    localparam logic KIND_SQRT  = 1'b0;
    localparam logic KIND_RSQRT = 1'b1;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic        special;
        logic [31:0] spec_bits;
        logic [7:0]  ne;
        logic [24:0] m;
        logic [31:0] a;
        logic [31:0] b;
    } t_word;

endpackage

@@ sv/float32_sqrt_rsqrt_unit.sv @@
// ============================================================================
// float32_sqrt_rsqrt_unit - pipelined single-precision sqrt and rsqrt
// Correctly rounded square root or reciprocal square root of one IEEE
// single-precision word per cycle.
// ============================================================================
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------
//  operand   | i_start / o_busy       | i_kind, i_operand_bits
//  result    | o_valid (one cycle)    | o_result_bits
//
//  A word is taken at every edge with i_start high; o_busy stays low, so a
//  new operand may enter in every cycle. Its result passes through 2 prepare
//  stages, 13 normalization steps (one per stage) and 5 fixup stages around
//  the multipliers.
//  Synchronous active-low reset clears every valid bit; words in flight drop.
//  The receiver cannot stall, so the pipeline never holds.
//
module float32_sqrt_rsqrt_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_kind,
    input  logic [31:0] i_operand_bits,
    output logic        o_valid,
    output logic [31:0] o_result_bits
);

    // words between the sections; entry 0 comes from the prepare section
    frsq_pkg::t_word w_chain [frsq_pkg::ITER_STEPS+1];

    // decode, normalize and seed
    frsq_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start),
        .i_kind  (i_kind),
        .i_bits  (i_operand_bits),
        .o_word  (w_chain[0])
    );

    // advance through the normalization steps, shift 1 up to 13
    for (genvar g = 0; g < frsq_pkg::ITER_STEPS; g++) begin : g_iter
        frsq_iter_stage #(
            .K (g + 1)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (w_chain[g]),
            .o_word  (w_chain[g+1])
        );
    end

    // correct, check the last bit and pack the result word
    frsq_fixup u_fixup (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_word        (w_chain[frsq_pkg::ITER_STEPS]),
        .o_valid       (o_valid),
        .o_result_bits (o_result_bits)
    );

    // fully pipelined: never refuse an operand
    assign o_busy = 1'b0;

endmodule

@@ sv/frsq_prep.sv @@
// ============================================================================
// frsq_prep - operand decode and normalization
// Two register stages: capture and find the subnormal shift, then normalize,
// halve the exponent and seed the iteration words.
// ============================================================================
module frsq_prep (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_kind,
    input  logic [31:0]      i_bits,
    output frsq_pkg::t_word  o_word
);

    logic        r_valid, n_valid;
    logic        r_kind, n_kind;
    logic [31:0] r_bits, n_bits;
    logic [4:0]  r_shift, n_shift;
    frsq_pkg::t_word r_word, n_word;

    // leading-one search for the subnormal fraction
    always_comb begin
        n_valid = i_valid;
        n_kind  = i_kind;
        n_bits  = i_bits;
        n_shift = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (i_bits[i]) begin
                n_shift = 5'(23 - i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_kind  <= 1'b0;
            r_bits  <= '0;
            r_shift <= '0;
        end else begin
            r_valid <= n_valid;
            r_kind  <= n_kind;
            r_bits  <= n_bits;
            r_shift <= n_shift;
        end
    end

    logic [7:0]  efield;
    logic [23:0] sig;
    logic [24:0] sig_adj;
    logic [9:0]  e;
    logic [9:0]  e_half;
    logic [31:0] shifted;

    always_comb begin
        efield  = r_bits[30:23];
        shifted = r_bits << r_shift;
        if (efield != 8'd0) begin
            sig = {1'b1, r_bits[22:0]};
            e   = 10'({2'b00, efield}) - 10'd127;
        end else begin
            sig = shifted[23:0];
            e   = 10'(-126) - 10'({5'b0, r_shift});
        end
        sig_adj = e[0] ? {sig, 1'b0} : {1'b0, sig};
        e_half  = 10'($signed(e) >>> 1);

        n_word.valid     = r_valid;
        n_word.kind      = r_kind;
        n_word.m         = sig_adj;
        n_word.a         = {1'b0, sig_adj, 6'b0};
        n_word.b         = (r_kind == frsq_pkg::KIND_RSQRT) ? frsq_pkg::RSQRT_B_INIT
                                                            : {sig_adj, 7'b0};
        n_word.ne        = (r_kind == frsq_pkg::KIND_RSQRT) ? 8'(10'd125 - e_half)
                                                            : 8'(e_half + 10'd126);
        n_word.special   = 1'b1;
        n_word.spec_bits = frsq_pkg::QNAN_BITS;
        if (r_bits[31]) begin
            if (r_bits == frsq_pkg::NEG_ZERO_BITS) begin
                n_word.spec_bits = r_kind ? frsq_pkg::NEG_INF_BITS : frsq_pkg::NEG_ZERO_BITS;
            end
        end else if (efield == 8'hFF) begin
            if (r_bits == frsq_pkg::POS_INF_BITS) begin
                n_word.spec_bits = r_kind ? frsq_pkg::ZERO_BITS : frsq_pkg::POS_INF_BITS;
            end
        end else if (r_bits == frsq_pkg::ZERO_BITS) begin
            n_word.spec_bits = r_kind ? frsq_pkg::POS_INF_BITS : frsq_pkg::ZERO_BITS;
        end else begin
            n_word.special = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

@@ sv/frsq_iter_stage.sv @@
// ============================================================================
// frsq_iter_stage - one shift-and-add normalization step
// Try a * (1 + 2^-K)^2; keep it when it stays below 2^31 and scale b by
// (1 + 2^-K) to match. One register stage.
// ============================================================================
module frsq_iter_stage #(
    parameter int K = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  frsq_pkg::t_word  i_word,
    output frsq_pkg::t_word  o_word
);

    logic [33:0] t1, t2;
    frsq_pkg::t_word r_word, n_word;

    always_comb begin
        t1     = {2'b00, i_word.a} + ({2'b00, i_word.a} >> K);
        t2     = t1 + (t1 >> K);
        n_word = i_word;
        if (t2[33:31] == 3'b000) begin
            n_word.a = t2[31:0];
            n_word.b = i_word.b + (i_word.b >> K);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

@@ sv/frsq_fixup.sv @@
// ============================================================================
// frsq_fixup - multiply correction, last-bit check and packing
// Five register stages: a*b, correction, square, check products, result.
// ============================================================================
module frsq_fixup (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  frsq_pkg::t_word  i_word,
    output logic             o_valid,
    output logic [31:0]      o_result_bits
);

    // stage 1: full product of a and b
    frsq_pkg::t_word r_w1;
    logic [63:0]     r_prod, n_prod;
    assign n_prod = 64'(i_word.a) * 64'(i_word.b);

    // stage 2: corrected root, trimmed for the selected kind
    frsq_pkg::t_word r_w2;
    logic [25:0]     r_x, n_x;
    logic [31:0]     root;
    always_comb begin
        root = (r_w1.b + (r_w1.b >> 1)) - r_prod[63:32];
        n_x  = (r_w1.kind == frsq_pkg::KIND_RSQRT) ? (root[31:6] | 26'd1)
                                                   : {2'b00, root[31:8]};
    end

    // stage 3: square of the candidate
    frsq_pkg::t_word r_w3;
    logic [25:0]     r_x3;
    logic [51:0]     r_sq, n_sq;
    assign n_sq = 52'(r_x) * 52'(r_x);

    // stage 4: residual check for sqrt, product terms for rsqrt
    frsq_pkg::t_word r_w4;
    logic [25:0]     r_x4;
    logic            r_bump, n_bump;
    logic [56:0]     r_plo, n_plo;
    logic [44:0]     r_phi, n_phi;
    logic [51:0]     diff;
    always_comb begin
        diff   = {4'b0, r_w3.m, 23'b0} - r_sq;
        n_bump = $signed(diff) > $signed({26'b0, r_x3});
        n_plo  = 57'(r_w3.m) * 57'(r_sq[31:0]);
        n_phi  = 45'(r_w3.m) * 45'(r_sq[51:32]);
    end

    // stage 5: pick the last bit and pack exponent and significand
    logic            r_valid, n_valid;
    logic [31:0]     r_res, n_res;
    logic [45:0]     s;
    logic [26:0]     u_inc;
    logic [31:0]     sig;
    always_comb begin
        s     = {21'b0, r_plo[56:32]} + {1'b0, r_phi};
        u_inc = {1'b0, r_x4} + 27'd1;
        if (r_w4.kind == frsq_pkg::KIND_RSQRT) begin
            sig = (s[45:32] >= 14'd512) ? {7'b0, r_x4[25:1]} : {6'b0, u_inc[26:1]};
        end else begin
            sig = {8'b0, r_x4[23:0]} + {31'b0, r_bump};
        end
        n_valid = r_w4.valid;
        n_res   = r_w4.special ? r_w4.spec_bits : ({1'b0, r_w4.ne, 23'b0} + sig);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1    <= '0;
            r_w2    <= '0;
            r_w3    <= '0;
            r_w4    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_w1    <= i_word;
            r_w2    <= r_w1;
            r_w3    <= r_w2;
            r_w4    <= r_w3;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_x    <= n_x;
        r_x3   <= r_x;
        r_sq   <= n_sq;
        r_x4   <= r_x3;
        r_bump <= n_bump;
        r_plo  <= n_plo;
        r_phi  <= n_phi;
        r_res  <= n_res;
    end

    assign o_valid       = r_valid;
    assign o_result_bits = r_res;

endmodule

@@ verif/tb_float32_sqrt_rsqrt_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_float32_sqrt_rsqrt_unit - regression of the float32 sqrt / rsqrt unit
// Drives operand words through the command handshake, predicts every result
// with an independent bit-exact model of the rounding algorithm and checks
// each strobed result word in order against the oldest prediction.
// ============================================================================
class root_scoreboard;
    logic [31:0] pending_roots[$];
    int          n_errors;

    function new();
        n_errors = 0;
    endfunction

    // Shift-and-add normalization shared by both operations.
    static function logic [31:0] converge(logic [31:0] a_in, logic [31:0] b_in);
        logic [31:0] a, b, t, hi;
        logic [63:0] prod;
        int          k;
        a = a_in << 6;
        b = b_in;
        t = a + (a >> 1);
        if (!t[31]) begin
            t = t + (t >> 1);
            if (!t[31]) begin
                a = t;
                b = b + (b >> 1);
            end
        end
        for (k = 2; k < 14; k++) begin
            t = a + (a >> k);
            t = t + (t >> k);
            if (!t[31]) begin
                a = t;
                b = b + (b >> k);
            end
        end
        prod = 64'(a) * 64'(b);
        hi = prod[63:32];
        b = b + (b >> 1);
        return b - hi;
    endfunction

    static function logic [31:0] root_sig(logic [31:0] m);
        logic [31:0] r;
        logic [63:0] sq, scaled;
        r = converge(m, m << 7) >> 8;
        sq = 64'(r) * 64'(r);
        scaled = 64'(m) << 23;
        // residual above r means the true root lies past the midpoint
        if ($signed(scaled - sq) > $signed(64'(r))) r = r + 32'd1;
        return r;
    endfunction

    static function logic [31:0] inv_root_sig(logic [31:0] m);
        logic [31:0] u, sq_lo, sq_hi, b_hi, p;
        logic [63:0] sq, c, s, t;
        u = (converge(m, frsq_pkg::RSQRT_B_INIT) >> 6) | 32'd1;
        sq = 64'(u) * 64'(u);
        sq_hi = sq[63:32];
        sq_lo = sq[31:0];
        t = 64'(m) * 64'(sq_lo);
        b_hi = t[63:32];
        c = 64'(m) * 64'(sq_hi);
        s = 64'(b_hi) + c;
        p = s[63:32];
        if (p >= 32'd512) return u >> 1;
        return (u + 32'd1) >> 1;
    endfunction

    static function logic [31:0] root_of(logic kind, logic [31:0] x);
        logic [7:0]  ef;
        logic [31:0] sig;
        int          e, s, he;
        ef = x[30:23];
        if (x[31]) begin
            if (x == frsq_pkg::NEG_ZERO_BITS)
                return kind ? frsq_pkg::NEG_INF_BITS : frsq_pkg::NEG_ZERO_BITS;
            return frsq_pkg::QNAN_BITS;
        end
        if (ef == 8'hFF) begin
            if (x == frsq_pkg::POS_INF_BITS)
                return kind ? frsq_pkg::ZERO_BITS : frsq_pkg::POS_INF_BITS;
            return frsq_pkg::QNAN_BITS;
        end
        if (x == 0) return kind ? frsq_pkg::POS_INF_BITS : frsq_pkg::ZERO_BITS;
        if (ef != 0) begin
            sig = {8'd0, 1'b1, x[22:0]};
            e = int'(ef) - 127;
        end else begin
            s = 0;
            sig = x;
            while (s < 24 && !sig[23]) begin
                sig = sig << 1;
                s++;
            end
            e = -126 - s;
        end
        he = ((e + 256) >>> 1) - 128;
        if ((e + 256) % 2) sig = sig << 1;
        if (kind == frsq_pkg::KIND_SQRT)
            return (32'(he + 126) << 23) + root_sig(sig);
        return (32'(125 - he) << 23) + inv_root_sig(sig);
    endfunction

    function void note_operand(logic kind, logic [31:0] x);
        pending_roots.push_back(root_of(kind, x));
    endfunction

    function void check_result(logic [31:0] got);
        logic [31:0] want;
        if (pending_roots.size() == 0) begin
            $error("result_bits: none expected, actual %08h", got);
            n_errors++;
            return;
        end
        want = pending_roots.pop_front();
        if (got !== want) begin
            $error("result_bits: expected %08h, actual %08h", want, got);
            n_errors++;
        end
    endfunction
endclass

module tb_float32_sqrt_rsqrt_unit;

    localparam int LATENCY = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_kind = 1'b0;
    logic [31:0] i_operand_bits = '0;
    logic        o_busy;
    logic        o_valid;
    logic [31:0] o_result_bits;

    root_scoreboard sb = new();
    int             gap_pct = 0;

    float32_sqrt_rsqrt_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_kind         (i_kind),
        .i_operand_bits (i_operand_bits),
        .o_valid        (o_valid),
        .o_result_bits  (o_result_bits)
    );

    always #1 i_clk = ~i_clk;

    // Sample results at the rising edge; the receiver never stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_result_bits);
    end

    // Present one word, hold it until an edge takes it, then drop start
    // only if the sender idles before the next word.
    task automatic send_word(input logic kind, input logic [31:0] x);
        while (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_kind <= kind;
        i_operand_bits <= x;
        do @(posedge i_clk); while (o_busy);
        sb.note_operand(kind, x);
        @(negedge i_clk);
    endtask

    task automatic hold_off();
        i_start <= 1'b0;
        @(negedge i_clk);
    endtask

    // Random operand biased toward normal and subnormal positives, with
    // specials and negatives mixed in.
    function automatic logic [31:0] random_operand();
        logic [31:0] x;
        int          pick;
        x = $urandom();
        pick = $urandom_range(99, 0);
        if (pick < 60) x[31] = 1'b0;
        else if (pick < 75) x = {1'b0, 8'd0, x[22:0] >> $urandom_range(22, 0)};
        else if (pick < 80) x = {x[31], 8'hFF, ($urandom_range(1, 0) ? 23'd0 : x[22:0])};
        else if (pick < 85) x = {x[31], 31'd0};
        else if (pick < 90) x = {1'b0, x[30:23], 23'h7FFFFF};
        return x;
    endfunction

    initial begin
        logic [31:0] directed[$];
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        directed = {32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                    32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'hBF80_0000,
                    32'h0000_0001, 32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF,
                    32'h3F80_0000, 32'h4080_0000, 32'h4000_0000, 32'h3FFF_FFFF};
        foreach (directed[i]) begin
            send_word(frsq_pkg::KIND_SQRT, directed[i]);
            send_word(frsq_pkg::KIND_RSQRT, directed[i]);
        end

        // Phase one: sender idles about a third of the time.
        gap_pct = 32;
        repeat (600) send_word(1'($urandom_range(1, 0)), random_operand());

        // Let the pipeline drain completely before going on.
        hold_off();
        while (sb.pending_roots.size() != 0) @(negedge i_clk);

        gap_pct = 54;
        repeat (500) send_word(1'($urandom_range(1, 0)), random_operand());
        gap_pct = 0;
        repeat (600) send_word(1'($urandom_range(1, 0)), random_operand());
        hold_off();

        while (sb.pending_roots.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
        if (sb.n_errors == 0 && sb.pending_roots.size() == 0)
            $display("float32_sqrt_rsqrt_unit regression: pass");
        else
            $display("float32_sqrt_rsqrt_unit regression: fail");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #200000;
        $display("float32_sqrt_rsqrt_unit regression: fail");
        $finish;
    end
endmodule
